// ===== hdl/flsa_pkg.sv =====
// Shared types and constants for the free-list slot allocator.
// No dependencies; imported by flsa_div and free_list_slot_allocator_core.
package flsa_pkg;

   localparam int SLOTS          = 256;
   localparam int IDX_W          = $clog2(SLOTS);
   localparam int CNT_W          = 9;
   localparam int ADDR_W         = 32;
   localparam int SIZE_W         = 16;
   localparam int REM_W          = SIZE_W + IDX_W;
   localparam int PROD_W         = SIZE_W + IDX_W;
   localparam int DIV_STEP_W     = $clog2(IDX_W);
   localparam int MIN_SLOT_BYTES = 4;
   localparam int RSP_DATA_W     = 48;
   localparam int CSR_INDEX_W    = 1;
   localparam int CSR_DATA_W     = 32;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_POOL_BASE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_BYTES = 1'b1;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_EXHAUSTED = 3'd1,
      STATUS_OUTSIDE   = 3'd2,
      STATUS_FULL      = 3'd3,
      STATUS_NULL      = 3'd4
   } status_type;

   // divider result, valid when done is high
   typedef struct packed {
      logic             done;
      logic             outside;
      logic [IDX_W-1:0] quot;
   } div_rsp_type;

endpackage

// ===== hdl/flsa_div.sv =====
// Iterative slot index divider: offset / slot size, one quotient bit per cycle.
// Depends on flsa_pkg.
module flsa_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [flsa_pkg::ADDR_W-1:0]   offset,
   input  logic [flsa_pkg::SIZE_W-1:0]   size,
   output flsa_pkg::div_rsp_type         div_rsp
);
   import flsa_pkg::*;

   typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_DONE} dv_state_type;

   dv_state_type           state_ff, state_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic [REM_W-1:0]       dsh_ff, dsh_in;
   logic [IDX_W-1:0]       quot_ff, quot_in;
   logic [DIV_STEP_W-1:0]  step_ff, step_in;
   logic                   outside_ff, outside_in;
   logic [REM_W-1:0]       limit;
   logic                   ge;

   // quotient fits in IDX_W bits only if offset < size * SLOTS
   assign limit = {size, {IDX_W{1'b0}}};
   assign ge    = (rem_ff >= dsh_ff);

   always_comb begin
      state_in   = state_ff;
      rem_in     = rem_ff;
      dsh_in     = dsh_ff;
      quot_in    = quot_ff;
      step_in    = step_ff;
      outside_in = outside_ff;
      unique case (state_ff)
         DV_IDLE: begin
            if (start) begin
               outside_in = (|offset[ADDR_W-1:REM_W]) || (offset[REM_W-1:0] >= limit);
               rem_in     = offset[REM_W-1:0];
               dsh_in     = REM_W'({size, {(IDX_W-1){1'b0}}});
               quot_in    = '0;
               step_in    = DIV_STEP_W'(IDX_W - 1);
               state_in   = outside_in ? DV_DONE : DV_RUN;
            end
         end
         DV_RUN: begin
            if (ge) begin
               rem_in = rem_ff - dsh_ff;
            end
            dsh_in  = dsh_ff >> 1;
            quot_in = {quot_ff[IDX_W-2:0], ge};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = DV_DONE;
            end
         end
         DV_DONE: begin
            state_in = DV_IDLE;
         end
         default: state_in = DV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rem_ff     <= rem_in;
      dsh_ff     <= dsh_in;
      quot_ff    <= quot_in;
      step_ff    <= step_in;
      outside_ff <= outside_in;
   end

   assign div_rsp.done    = (state_ff == DV_DONE);
   assign div_rsp.outside = outside_ff;
   assign div_rsp.quot    = quot_ff;

endmodule

// ===== hdl/free_list_slot_allocator_core.sv =====
// LIFO free-list slot allocator, top level: stack memory, control, output stage.
// Depends on flsa_pkg and flsa_div.
//
// A pool of SLOTS equal slots starting at pool_base is handed out through a
// LIFO stack of free slot indices held in a synchronous memory (registered
// read). Reset leaves SLOTS-1 down to 0 on the stack through per-entry valid
// bits, so no clearing pass is needed and the block takes beats right after
// reset. One request is processed at a time. An allocate runs through memory
// read, index times slot size multiply, base add and output load. A free
// waits on the iterative divider, which works out the 8-bit slot index one
// quotient bit at a time and then reports done. A free whose address lies
// outside the pool skips the quotient bits. A finished result sits in the
// output register, so the next request beat is taken while the previous
// response still waits for rsp_tready. The user must write pool_base and
// slot_bytes only while the block is idle; the block does not enforce this.
// A slot size below four behaves as four.
module free_list_slot_allocator_core (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [31:0]                        req_tdata,  // [31:0] address
   input  logic                               req_tuser,  // [0] action (0 alloc, 1 free)
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [flsa_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // [31:0] slot_address,
                                                          // [34:32] status,
                                                          // [43:35] free_count, rest zero
   // configuration
   input  logic                               csr_we,
   input  logic [flsa_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [flsa_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import flsa_pkg::*;

   typedef enum logic [2:0] {ST_IDLE, ST_RD, ST_MUL, ST_DIV, ST_OUT} state_type;

   // control and config
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    top_ff, top_in;
   logic [ADDR_W-1:0]   pool_base_ff, pool_base_in;
   logic [SIZE_W-1:0]   slot_bytes_ff, slot_bytes_in;
   // working result
   logic [ADDR_W-1:0]   res_addr_ff, res_addr_in;
   status_type          res_status_ff, res_status_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   // output stage
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;

   // stack memory, reset value supplied by valid bits
   logic [IDX_W-1:0]    stack_mem [SLOTS];
   logic [SLOTS-1:0]    vld_ff;
   logic [IDX_W-1:0]    rd_data_ff;
   logic                rd_vld_ff;
   logic [IDX_W-1:0]    rd_addr_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   logic [IDX_W-1:0]    pop_idx;

   logic                req_beat;
   logic                div_start;
   logic [ADDR_W-1:0]   offset;
   logic [SIZE_W-1:0]   eff_size;
   div_rsp_type         div_rsp;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign eff_size   = (slot_bytes_ff < SIZE_W'(MIN_SLOT_BYTES)) ?
                       SIZE_W'(MIN_SLOT_BYTES) : slot_bytes_ff;
   assign offset     = req_tdata - pool_base_ff;
   assign div_start  = req_beat && req_tuser && (req_tdata != '0);

   // entry below the top is read every cycle; used only on an allocate
   assign rd_addr    = IDX_W'(top_ff - 1'b1);
   assign mem_waddr  = top_ff[IDX_W-1:0];
   // an entry never written still holds its reset value SLOTS-1-i
   assign pop_idx    = rd_vld_ff ? rd_data_ff : IDX_W'(SLOTS - 1) - rd_addr_ff;

   flsa_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .offset  (offset),
      .size    (eff_size),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in      = state_ff;
      top_in        = top_ff;
      pool_base_in  = pool_base_ff;
      slot_bytes_in = slot_bytes_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      mem_we        = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_POOL_BASE:  pool_base_in  = csr_wdata;
            CSR_SLOT_BYTES: slot_bytes_in = csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               res_addr_in   = '0;
               res_status_in = STATUS_OK;
               if (!req_tuser) begin
                  if (top_ff == '0) begin
                     res_status_in = STATUS_EXHAUSTED;
                     state_in      = ST_OUT;
                  end else begin
                     top_in   = top_ff - 1'b1;
                     state_in = ST_RD;
                  end
               end else if (req_tdata == '0) begin
                  res_status_in = STATUS_NULL;
                  state_in      = ST_OUT;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_RD: begin
            prod_in  = PROD_W'(pop_idx) * PROD_W'(eff_size);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            res_addr_in = pool_base_ff + ADDR_W'(prod_ff);
            state_in    = ST_OUT;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (div_rsp.outside) begin
                  res_status_in = STATUS_OUTSIDE;
               end else if (top_ff == CNT_W'(SLOTS)) begin
                  res_status_in = STATUS_FULL;  // double free
               end else begin
                  mem_we = 1'b1;
                  top_in = top_ff + 1'b1;
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               rsp_count_in  = top_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         top_ff        <= CNT_W'(SLOTS);
         pool_base_ff  <= '0;
         slot_bytes_ff <= SIZE_W'(64);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         top_ff        <= top_in;
         pool_base_ff  <= pool_base_in;
         slot_bytes_ff <= slot_bytes_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      prod_ff       <= prod_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // stack memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= div_rsp.quot;
      end
      rd_data_ff <= stack_mem[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            vld_ff[mem_waddr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - ADDR_W - 3 - CNT_W){1'b0}},
                        rsp_count_ff, rsp_status_ff, rsp_addr_ff};

   // stack depth never passes the pool size
   assert property (@(posedge clock) disable iff (reset) top_ff <= CNT_W'(SLOTS))
      else $error("stack_top above pool size");

   // a push only happens with room on the stack
   assert property (@(posedge clock) disable iff (reset) mem_we |-> top_ff < CNT_W'(SLOTS))
      else $error("push onto full stack");

   // divider reports only while the control waits for it
   assert property (@(posedge clock) disable iff (reset) div_rsp.done |-> state_ff == ST_DIV)
      else $error("divider done outside wait state");

   // an accepted beat always leaves idle
   assert property (@(posedge clock) disable iff (reset) req_beat |=> state_ff != ST_IDLE)
      else $error("request beat not taken up");

endmodule
